FILE: rtl/core/dre_pkg.sv
`timescale 1ns / 1ps

package dre_pkg;

    localparam int MAX_NODES_DEF  = 64;
    localparam int MAX_EDGES_DEF  = 256;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int RESULT_CAP     = 64;
    localparam int FIELD_WIDTH    = 16;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic                   mode;
        logic [FIELD_WIDTH-1:0] node_a;
        logic [FIELD_WIDTH-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [FIELD_WIDTH-1:0] node_value;
        logic                   node_valid;
        logic                   last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       nscan;
        logic       wr_a;
        logic       wr_b;
        logic       wr_e;
        logic       qinit;
        logic       pop;
        logic       fetch;
        logic       escan;
        logic       load_status;
        logic       load_node;
        logic       last;
        logic [1:0] status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode;
        logic nscan_done;
        logic found_a;
        logic full;
        logic escan_done;
        logic last_node;
        logic out_free;
    } sts_t;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_NSCAN   = 11'b000_0000_0010,
        S_ADDCHK  = 11'b000_0000_0100,
        S_WRA     = 11'b000_0000_1000,
        S_WRB     = 11'b000_0001_0000,
        S_WRE     = 11'b000_0010_0000,
        S_QINIT   = 11'b000_0100_0000,
        S_POP     = 11'b000_1000_0000,
        S_FETCH   = 11'b001_0000_0000,
        S_ESCAN   = 11'b010_0000_0000,
        S_EMIT_ND = 11'b100_0000_0000
    } state_t;

endpackage

FILE: rtl/core/dre_ctrl.sv
`timescale 1ns / 1ps

module dre_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dre_pkg::sts_t sts,
    output dre_pkg::cmd_t cmd
);

    dre_pkg::state_t state_reg, state_next;
    logic            emit_st_reg, emit_st_next;
    logic [1:0]      res_status_reg, res_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dre_pkg::S_IDLE;
            emit_st_reg    <= 1'b0;
            res_status_reg <= dre_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            emit_st_reg    <= emit_st_next;
            res_status_reg <= res_status_next;
        end
    end

    // a status-only result waits in idle until the output slot is free
    assign req_ready = (state_reg == dre_pkg::S_IDLE) && !emit_st_reg;

    always_comb
    begin
        state_next      = state_reg;
        emit_st_next    = emit_st_reg;
        res_status_next = res_status_reg;
        cmd             = '0;
        cmd.status      = res_status_reg;
        case (state_reg)
            dre_pkg::S_IDLE:
            begin
                if (emit_st_reg)
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_status = 1'b1;
                        cmd.last        = 1'b1;
                        emit_st_next    = 1'b0;
                    end
                end
                else if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = dre_pkg::S_NSCAN;
                end
            end
            dre_pkg::S_NSCAN:
            begin
                cmd.nscan = 1'b1;
                if (sts.nscan_done)
                begin
                    if (sts.mode == dre_pkg::MODE_ADD)
                        state_next = dre_pkg::S_ADDCHK;
                    else if (sts.found_a)
                        state_next = dre_pkg::S_QINIT;
                    else
                    begin
                        res_status_next = dre_pkg::ST_UNKNOWN;
                        emit_st_next    = 1'b1;
                        state_next      = dre_pkg::S_IDLE;
                    end
                end
            end
            dre_pkg::S_ADDCHK:
            begin
                if (sts.full)
                begin
                    res_status_next = dre_pkg::ST_FULL;
                    emit_st_next    = 1'b1;
                    state_next      = dre_pkg::S_IDLE;
                end
                else
                    state_next = dre_pkg::S_WRA;
            end
            dre_pkg::S_WRA:
            begin
                cmd.wr_a   = 1'b1;
                state_next = dre_pkg::S_WRB;
            end
            dre_pkg::S_WRB:
            begin
                cmd.wr_b   = 1'b1;
                state_next = dre_pkg::S_WRE;
            end
            dre_pkg::S_WRE:
            begin
                cmd.wr_e        = 1'b1;
                res_status_next = dre_pkg::ST_OK;
                emit_st_next    = 1'b1;
                state_next      = dre_pkg::S_IDLE;
            end
            dre_pkg::S_QINIT:
            begin
                cmd.qinit  = 1'b1;
                state_next = dre_pkg::S_POP;
            end
            dre_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = dre_pkg::S_FETCH;
            end
            dre_pkg::S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = dre_pkg::S_ESCAN;
            end
            dre_pkg::S_ESCAN:
            begin
                cmd.escan = 1'b1;
                if (sts.escan_done)
                    state_next = dre_pkg::S_EMIT_ND;
            end
            dre_pkg::S_EMIT_ND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_node = 1'b1;
                    cmd.last      = sts.last_node;
                    cmd.status    = dre_pkg::ST_OK;
                    state_next    = sts.last_node ? dre_pkg::S_IDLE : dre_pkg::S_POP;
                end
            end
            default:
            begin
                state_next = dre_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dre_datapath.sv
`timescale 1ns / 1ps

module dre_datapath #(
    parameter int MAX_NODES = dre_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = dre_pkg::MAX_EDGES_DEF,
    parameter int ID_WIDTH  = dre_pkg::ID_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dre_pkg::req_t req,
    input  dre_pkg::cmd_t cmd,
    output dre_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dre_pkg::rsp_t rsp
);

    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int RW  = $clog2(dre_pkg::RESULT_CAP + 1);

    localparam logic [NCW:0]   NODE_LIMIT = (NCW + 1)'(MAX_NODES);
    localparam logic [NCW-1:0] QUEUE_LIMIT = NCW'(MAX_NODES);
    localparam logic [ECW-1:0] EDGE_LIMIT = ECW'(MAX_EDGES);
    localparam logic [RW-1:0]  CAP_LAST   = RW'(dre_pkg::RESULT_CAP - 1);

    logic [ID_WIDTH-1:0] node_mem  [MAX_NODES];
    logic [NW-1:0]       esrc_mem  [MAX_EDGES];
    logic [NW-1:0]       etgt_mem  [MAX_EDGES];
    logic [NW-1:0]       queue_mem [MAX_NODES];

    logic                mode_reg;
    logic [ID_WIDTH-1:0] id_a_reg, id_b_reg;
    logic [NCW-1:0]      node_count_reg;
    logic [ECW-1:0]      edge_count_reg;
    logic [NCW-1:0]      nidx_reg;
    logic                npend_reg;
    logic [NW-1:0]       npend_slot_reg;
    logic                found_a_reg, found_b_reg;
    logic [NW-1:0]       slot_a_reg, slot_b_reg;
    logic [ID_WIDTH-1:0] node_rd_reg;
    logic [ECW-1:0]      eidx_reg;
    logic                epend_reg;
    logic [NW-1:0]       esrc_rd_reg, etgt_rd_reg;
    logic [NW-1:0]       queue_rd_reg;
    logic [NW-1:0]       cur_reg;
    logic [NCW-1:0]      head_reg, tail_reg;
    logic [RW-1:0]       nres_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic                rsp_valid_reg;
    dre_pkg::rsp_t       rsp_reg;

    logic          node_rd_en;
    logic [NW-1:0] node_rd_addr;
    logic          node_we;
    logic [NW-1:0] node_wr_addr;
    logic [ID_WIDTH-1:0] node_wr_data;
    logic          edge_rd_en;
    logic          q_we;
    logic [NW-1:0] q_wr_addr, q_wr_data;
    logic [1:0]    need;
    logic          nscan_rd;
    logic          hit;

    assign nscan_rd     = cmd.nscan && (nidx_reg < node_count_reg);
    assign node_rd_en   = nscan_rd || cmd.fetch;
    assign node_rd_addr = cmd.fetch ? queue_rd_reg : nidx_reg[NW-1:0];
    assign edge_rd_en   = cmd.escan && (eidx_reg < edge_count_reg);

    // new slots: file id first, then the dependency id
    always_comb
    begin
        node_we      = 1'b0;
        node_wr_addr = node_count_reg[NW-1:0];
        node_wr_data = id_a_reg;
        if (cmd.wr_a && !found_a_reg)
            node_we = 1'b1;
        if (cmd.wr_b && !found_b_reg && (id_b_reg != id_a_reg))
        begin
            node_we      = 1'b1;
            node_wr_data = id_b_reg;
        end
    end

    assign hit = cmd.escan && epend_reg && (esrc_rd_reg == cur_reg)
                 && !visited_reg[etgt_rd_reg] && (tail_reg < QUEUE_LIMIT);

    always_comb
    begin
        q_we      = 1'b0;
        q_wr_addr = tail_reg[NW-1:0];
        q_wr_data = etgt_rd_reg;
        if (cmd.qinit)
        begin
            q_we      = 1'b1;
            q_wr_addr = '0;
            q_wr_data = slot_a_reg;
        end
        else if (hit)
            q_we = 1'b1;
    end

    assign need = 2'(!found_a_reg) + 2'(!found_b_reg && (id_b_reg != id_a_reg));

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wr_addr] <= node_wr_data;
        if (node_rd_en)
            node_rd_reg <= node_mem[node_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_e)
        begin
            esrc_mem[edge_count_reg[EW-1:0]] <= slot_b_reg;
            etgt_mem[edge_count_reg[EW-1:0]] <= slot_a_reg;
        end
        if (edge_rd_en)
        begin
            esrc_rd_reg <= esrc_mem[eidx_reg[EW-1:0]];
            etgt_rd_reg <= etgt_mem[eidx_reg[EW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[q_wr_addr] <= q_wr_data;
        if (cmd.pop)
            queue_rd_reg <= queue_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= req.mode;
            id_a_reg <= ID_WIDTH'(req.node_a);
            id_b_reg <= ID_WIDTH'(req.node_b);
        end
        if (nscan_rd)
            npend_slot_reg <= nidx_reg[NW-1:0];
        if (cmd.fetch)
            cur_reg <= queue_rd_reg;
        if (cmd.load_status || cmd.load_node)
        begin
            rsp_reg.status     <= cmd.status;
            rsp_reg.node_value <= cmd.load_node ? dre_pkg::FIELD_WIDTH'(node_rd_reg) : '0;
            rsp_reg.node_valid <= cmd.load_node;
            rsp_reg.last       <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            edge_count_reg <= '0;
            nidx_reg       <= '0;
            npend_reg      <= 1'b0;
            found_a_reg    <= 1'b0;
            found_b_reg    <= 1'b0;
            slot_a_reg     <= '0;
            slot_b_reg     <= '0;
            eidx_reg       <= '0;
            epend_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            nres_reg       <= '0;
            visited_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_status || cmd.load_node)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;

            if (cmd.capture)
            begin
                nidx_reg    <= '0;
                npend_reg   <= 1'b0;
                found_a_reg <= 1'b0;
                found_b_reg <= 1'b0;
            end
            else if (cmd.nscan)
            begin
                npend_reg <= nscan_rd;
                if (nscan_rd)
                    nidx_reg <= nidx_reg + 1'b1;
                if (npend_reg)
                begin
                    if (!found_a_reg && (node_rd_reg == id_a_reg))
                    begin
                        found_a_reg <= 1'b1;
                        slot_a_reg  <= npend_slot_reg;
                    end
                    if (!found_b_reg && (node_rd_reg == id_b_reg))
                    begin
                        found_b_reg <= 1'b1;
                        slot_b_reg  <= npend_slot_reg;
                    end
                end
            end

            if (cmd.wr_a && !found_a_reg)
            begin
                found_a_reg    <= 1'b1;
                slot_a_reg     <= node_count_reg[NW-1:0];
                node_count_reg <= node_count_reg + 1'b1;
            end
            if (cmd.wr_b && !found_b_reg)
            begin
                found_b_reg <= 1'b1;
                if (id_b_reg == id_a_reg)
                    slot_b_reg <= slot_a_reg;
                else
                begin
                    slot_b_reg     <= node_count_reg[NW-1:0];
                    node_count_reg <= node_count_reg + 1'b1;
                end
            end
            if (cmd.wr_e)
                edge_count_reg <= edge_count_reg + 1'b1;

            if (cmd.qinit)
            begin
                visited_reg <= MAX_NODES'(1) << slot_a_reg;
                head_reg    <= '0;
                tail_reg    <= NCW'(1);
                nres_reg    <= '0;
            end
            if (cmd.pop)
                head_reg <= head_reg + 1'b1;
            if (cmd.fetch)
            begin
                eidx_reg  <= '0;
                epend_reg <= 1'b0;
            end
            if (cmd.escan)
            begin
                epend_reg <= edge_rd_en;
                if (edge_rd_en)
                    eidx_reg <= eidx_reg + 1'b1;
                if (hit)
                begin
                    visited_reg[etgt_rd_reg] <= 1'b1;
                    tail_reg                 <= tail_reg + 1'b1;
                end
            end
            if (cmd.load_node)
                nres_reg <= nres_reg + 1'b1;
        end
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.nscan_done = (nidx_reg == node_count_reg) && !npend_reg;
        sts.found_a    = found_a_reg;
        sts.full       = (({1'b0, node_count_reg} + (NCW + 1)'(need)) > NODE_LIMIT)
                         || (edge_count_reg >= EDGE_LIMIT);
        sts.escan_done = (eidx_reg == edge_count_reg) && !epend_reg;
        sts.last_node  = (head_reg == tail_reg) || (nres_reg == CAP_LAST);
        sts.out_free   = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= QUEUE_LIMIT)
        else $error("queue tail beyond node slots");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= QUEUE_LIMIT)
        else $error("node count beyond node slots");

    a_enqueue_marks: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> visited_reg[$past(etgt_rd_reg)])
        else $error("enqueued node not marked visited");
`endif

endmodule

FILE: rtl/core/dependency_reachability_engine.sv
`timescale 1ns / 1ps

// dependency graph with breadth-first reachability queries. an add beat (mode 0) records
// that node_a depends on node_b: unseen ids get slots by a linear search of the id table,
// and the edge is stored reversed. a query beat (mode 1) streams every node that reaches
// node_a, start included, once each in discovery order, last set on the final beat; an
// unknown start gives one beat with status 2, a full node or edge table drops the add and
// gives status 1. one item at a time: an add searches the id table over the single-port
// node memory, then does one write per cycle, then gives the status result; a query
// searches the id table, then each reached node scans the whole edge memory one entry
// per cycle, and the stream stops after RESULT_CAP beats. every result also waits for
// the output slot to free up. a result held in the output register never blocks the
// next beat from being taken; one still waiting for the output slot does.
module dependency_reachability_engine #(
    parameter int MAX_NODES = dre_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = dre_pkg::MAX_EDGES_DEF,
    parameter int ID_WIDTH  = dre_pkg::ID_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dre_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dre_pkg::rsp_t rsp
);

    // command and status between the sequencer and the tables
    dre_pkg::cmd_t cmd;
    dre_pkg::sts_t sts;

    dre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // id table, edge tables, work queue, visited flags and the output register
    dre_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .ID_WIDTH  (ID_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: tb/dependency_reachability_engine_test.sv
`timescale 1ns / 1ps

module dependency_reachability_engine_test;

    localparam int NODE_SLOTS = 64;
    localparam int EDGE_SLOTS = 256;
    localparam longint CYCLE_LIMIT = 64'd20000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    dre_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    dre_pkg::rsp_t rsp;

    dependency_reachability_engine uut (
        .clk       (clk),
        .rsp_ready (rsp_ready),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // graph mirror kept by the predictor
    logic [15:0] graph_ids [NODE_SLOTS];
    int          graph_nodes;
    int          dep_from [EDGE_SLOTS];
    int          dep_to   [EDGE_SLOTS];
    int          graph_edges;

    dre_pkg::rsp_t pending_beats [$];
    int     error_count;
    int     beats_seen;
    int     adds_sent;
    int     queries_sent;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int slot_of(logic [15:0] id);
        for (int i = 0; i < graph_nodes; i++)
            if (graph_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic dre_pkg::rsp_t make_beat(logic [1:0] st, logic [15:0] v, logic vld,
                                                logic lst);
        dre_pkg::rsp_t r;
        r.status     = st;
        r.node_value = v;
        r.node_valid = vld;
        r.last       = lst;
        return r;
    endfunction

    // append one beat to the expected stream
    function automatic void expect_beat(dre_pkg::rsp_t r);
        pending_beats = {pending_beats, r};
    endfunction

    // add: find or allocate slots, store the edge dependency -> file; a full table gives a status beat instead
    function automatic void predict_add(logic [15:0] a, logic [15:0] b);
        int sa;
        int sb;
        int need;
        sa = slot_of(a);
        sb = slot_of(b);
        need = 0;
        if (sa < 0)
            need++;
        if (sb < 0 && b != a)
            need++;
        if (graph_nodes + need > NODE_SLOTS || graph_edges >= EDGE_SLOTS)
        begin
            expect_beat(make_beat(dre_pkg::ST_FULL, 16'd0, 1'b0, 1'b1));
            return;
        end
        if (sa < 0)
        begin
            graph_ids[graph_nodes] = a;
            sa = graph_nodes;
            graph_nodes++;
        end
        if (sb < 0)
        begin
            if (b == a)
                sb = sa;
            else
            begin
                graph_ids[graph_nodes] = b;
                sb = graph_nodes;
                graph_nodes++;
            end
        end
        dep_from[graph_edges] = sb;
        dep_to[graph_edges]   = sa;
        graph_edges++;
        expect_beat(make_beat(dre_pkg::ST_OK, 16'd0, 1'b0, 1'b1));
    endfunction

    // query: breadth-first walk over reversed edges, discovery order
    function automatic void predict_dependents(logic [15:0] a);
        int  start;
        int  bfs [$];
        bit  seen [NODE_SLOTS];
        int  head;
        int  cur;
        int  n;
        dre_pkg::rsp_t r;
        start = slot_of(a);
        if (start < 0)
        begin
            expect_beat(make_beat(dre_pkg::ST_UNKNOWN, 16'd0, 1'b0, 1'b1));
            return;
        end
        for (int i = 0; i < NODE_SLOTS; i++)
            seen[i] = 1'b0;
        seen[start] = 1'b1;
        bfs = {bfs, start};
        head = 0;
        n = 0;
        while (head < bfs.size() && n < dre_pkg::RESULT_CAP)
        begin
            cur = bfs[head];
            head++;
            r = make_beat(dre_pkg::ST_OK, graph_ids[cur], 1'b1, 1'b0);
            n++;
            for (int e = 0; e < graph_edges; e++)
                if (dep_from[e] == cur && !seen[dep_to[e]] && bfs.size() < NODE_SLOTS)
                begin
                    seen[dep_to[e]] = 1'b1;
                    bfs = {bfs, dep_to[e]};
                end
            if (head >= bfs.size() || n >= dre_pkg::RESULT_CAP)
                r.last = 1'b1;
            expect_beat(r);
        end
    endfunction

    // one request beat, held until accepted
    task automatic send_beat(logic m, logic [15:0] a, logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req.mode   <= m;
        req.node_a <= a;
        req.node_b <= b;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (m == dre_pkg::MODE_ADD)
        begin
            predict_add(a, b);
            adds_sent++;
        end
        else
        begin
            predict_dependents(a);
            queries_sent++;
        end
    endtask

    // response stall pattern
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                $display("%0t unexpected beat: expected none, actual %p", $time, rsp);
                error_count++;
            end
            else
            begin
                if (rsp !== pending_beats[0])
                begin
                    $display("%0t mismatch: expected %p, actual %p",
                             $time, pending_beats[0], rsp);
                    error_count++;
                end
                void'(pending_beats.pop_front());
            end
        end
    end

    task automatic drain;
        req_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_pressure(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    logic [15:0] id_pool [$];

    function automatic logic [15:0] pick_id();
        if (id_pool.size() == 0 || $urandom_range(99) < 10)
            return 16'($urandom);
        return id_pool[$urandom_range(id_pool.size() - 1)];
    endfunction

    // extremes, self edge, cycle, repeat, unknown start
    task automatic test_directed;
        send_beat(dre_pkg::MODE_QUERY, 16'h0000, 16'hffff);
        send_beat(dre_pkg::MODE_ADD, 16'h0000, 16'hffff);
        send_beat(dre_pkg::MODE_ADD, 16'hffff, 16'h0000);
        send_beat(dre_pkg::MODE_ADD, 16'h5555, 16'h5555);
        send_beat(dre_pkg::MODE_ADD, 16'haaaa, 16'h0000);
        send_beat(dre_pkg::MODE_ADD, 16'haaaa, 16'h0000);
        send_beat(dre_pkg::MODE_ADD, 16'h5555, 16'haaaa);
        send_beat(dre_pkg::MODE_QUERY, 16'h0000, 16'h0000);
        send_beat(dre_pkg::MODE_QUERY, 16'hffff, 16'hffff);
        send_beat(dre_pkg::MODE_QUERY, 16'h5555, 16'h1234);
        send_beat(dre_pkg::MODE_QUERY, 16'h1234, 16'h0000);
        drain();
    endtask

    // chained and branching adds among a small id pool, queries on them
    task automatic test_random_graph(int count);
        logic [15:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = pick_id();
            if ($urandom_range(99) < 60)
            begin
                send_beat(dre_pkg::MODE_ADD, a, pick_id());
                if (slot_of(a) >= 0 && id_pool.size() < 40)
                    id_pool = {id_pool, a};
            end
            else
                send_beat(dre_pkg::MODE_QUERY, a, 16'($urandom));
        end
        drain();
    endtask

    // chain of new ids and a query on it, then fill the edge table
    task automatic test_table_full;
        for (int i = 0; i < 40; i++)
            send_beat(dre_pkg::MODE_ADD, 16'h8000 + 16'(i + 1), 16'h8000 + 16'(i));
        send_beat(dre_pkg::MODE_QUERY, 16'h8000, 16'h0000);
        for (int i = 0; i < EDGE_SLOTS && graph_edges < EDGE_SLOTS; i++)
            send_beat(dre_pkg::MODE_ADD, graph_ids[0], graph_ids[0]);
        send_beat(dre_pkg::MODE_ADD, 16'h0000, 16'hffff);
        send_beat(dre_pkg::MODE_QUERY, 16'h0000, 16'h0000);
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        cycle_count = 0;
        error_count = 0;
        beats_seen  = 0;
        adds_sent   = 0;
        queries_sent = 0;
        graph_nodes = 0;
        graph_edges = 0;
        set_pressure(0, 0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_pressure(0, 0);
        test_random_graph(50);
        set_pressure(70, 0);
        test_random_graph(40);
        set_pressure(0, 70);
        test_random_graph(40);
        set_pressure(16, 16);
        test_random_graph(40);
        set_pressure(0, 0);
        test_table_full();

        $display("covered %0d adds and %0d queries, %0d result beats checked",
                 adds_sent, queries_sent, beats_seen);
        $display("graph ended with %0d nodes and %0d edges", graph_nodes, graph_edges);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dre_pkg.sv
rtl/core/dre_ctrl.sv
rtl/core/dre_datapath.sv
rtl/core/dependency_reachability_engine.sv
tb/dependency_reachability_engine_test.sv
